FILE: sv/kct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_pkg
// Shared sizes, codes and types of the keyed context table.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;

  localparam int OP_W  = 2;
  localparam int RES_W = 29;
  localparam int CTX_W = 32;
  localparam int DAT_W = 32;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_SAVE   = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOENT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [RES_W-1:0] resource_id;
    logic [CTX_W-1:0] context_id;
    logic [DAT_W-1:0] data_in;
  } item_t;

  typedef struct packed {
    logic [RES_W-1:0] resource_id;
    logic [CTX_W-1:0] context_id;
    logic [DAT_W-1:0] data;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic             valid;
    logic [ST_W-1:0]  status;
    logic [DAT_W-1:0] data_out;
  } result_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } ram_req_t;

endpackage

FILE: sv/kct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_if
// Request and response channels of the keyed context table.
// ----------------------------------------------------------------------------
interface kct_req_if;
  logic                          valid;
  logic                          ready;
  logic [kct_pkg::OP_W-1:0]      op;
  logic [kct_pkg::RES_W-1:0]     resource_id;
  logic [kct_pkg::CTX_W-1:0]     context_id;
  logic [kct_pkg::DAT_W-1:0]     data_in;

  modport source (output valid, op, resource_id, context_id, data_in, input ready);
  modport sink   (input valid, op, resource_id, context_id, data_in, output ready);
endinterface

interface kct_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [kct_pkg::ST_W-1:0]      status;
  logic [kct_pkg::DAT_W-1:0]     data_out;

  modport source (output valid, status, data_out, input ready);
  modport sink   (input valid, status, data_out, output ready);
endinterface

FILE: sv/keyed_context_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_context_table
// Bounded key/value table keyed by (resource id, context id).
// ----------------------------------------------------------------------------
// One item at a time: each save, find or delete reads the entry RAM one slot
// per cycle from slot 0 and stops at the matching key, or after the last
// slot on a miss. The single RAM read port sets that rate. Valid bits live
// in flip-flops and are cleared by reset, so the table is usable in the
// cycle after reset. The result sits in an output register; a new item is
// accepted while it waits.
module keyed_context_table (
  input  logic      clk,
  input  logic      rst,
  kct_req_if.sink   req,
  kct_rsp_if.source rsp
);

  kct_pkg::item_t    in_item;
  kct_pkg::result_t  res;
  kct_pkg::ram_req_t ram_req;
  kct_pkg::entry_t   ram_rdata;
  logic              res_ready;

  logic                      out_valid;
  logic [kct_pkg::ST_W-1:0]  out_status;
  logic [kct_pkg::DAT_W-1:0] out_data;

  assign in_item.op          = req.op;
  assign in_item.resource_id = req.resource_id;
  assign in_item.context_id  = req.context_id;
  assign in_item.data_in     = req.data_in;

  assign res_ready = !out_valid || rsp.ready;

  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_item   (in_item),
    .res       (res),
    .res_ready (res_ready),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  kct_ram #(
    .WIDTH (kct_pkg::ENT_W),
    .DEPTH (kct_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid  <= 1'b1;
      out_status <= res.status;
      out_data   <= res.data_out;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.data_out = out_data;

endmodule

FILE: sv/kct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/kct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_ctrl
// Sequencer: scans the entry RAM for the key, tracks the first free slot,
// then writes back on a save and forms the result.
// ----------------------------------------------------------------------------
module kct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kct_pkg::item_t    in_item,
  output kct_pkg::result_t  res,
  input  logic              res_ready,
  output kct_pkg::ram_req_t ram_req,
  input  kct_pkg::entry_t   ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                      state;
  kct_pkg::item_t              item;
  logic [kct_pkg::CNT_W-1:0]   cnt;
  logic                        cmp_valid;
  logic [kct_pkg::IDX_W-1:0]   cmp_idx;
  logic                        hit;
  logic [kct_pkg::IDX_W-1:0]   hit_idx;
  logic [kct_pkg::DAT_W-1:0]   hit_data;
  logic                        free_found;
  logic [kct_pkg::IDX_W-1:0]   free_idx;
  logic [kct_pkg::ENTRIES-1:0] valid_bits;

  logic                        scan_end;
  logic                        match_now;
  logic                        issue;
  logic [kct_pkg::IDX_W-1:0]   issue_idx;
  logic                        finish;

  assign scan_end  = (cnt == kct_pkg::CNT_W'(kct_pkg::ENTRIES));
  assign issue_idx = cnt[kct_pkg::IDX_W-1:0];
  assign match_now = cmp_valid && valid_bits[cmp_idx]
                     && (ram_rdata.resource_id == item.resource_id)
                     && (ram_rdata.context_id == item.context_id);
  // stop issuing reads once the key has been seen
  assign issue     = (state == S_SCAN) && !scan_end && !hit && !match_now;
  assign finish    = (state == S_DONE) && res_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    res          = '0;
    res.valid    = (state == S_DONE);
    res.status   = kct_pkg::ST_NOENT;
    ram_req      = '0;
    ram_req.re   = issue;
    ram_req.raddr = issue_idx;
    ram_req.wdata.resource_id = item.resource_id;
    ram_req.wdata.context_id  = item.context_id;
    ram_req.wdata.data        = item.data_in;
    unique case (item.op)
      kct_pkg::OP_SAVE: begin
        if (hit) begin
          res.status    = kct_pkg::ST_OK;
          ram_req.we    = finish;
          ram_req.waddr = hit_idx;
        end else if (free_found) begin
          res.status    = kct_pkg::ST_OK;
          ram_req.we    = finish;
          ram_req.waddr = free_idx;
        end else begin
          res.status = kct_pkg::ST_FULL;
        end
      end
      kct_pkg::OP_FIND: begin
        if (hit) begin
          res.status   = kct_pkg::ST_OK;
          res.data_out = hit_data;
        end
      end
      kct_pkg::OP_DELETE: begin
        if (hit) begin
          res.status = kct_pkg::ST_OK;
        end
      end
      default: begin
        res.status = kct_pkg::ST_NOENT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      cmp_valid  <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      cnt        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item       <= in_item;
            cnt        <= '0;
            cmp_valid  <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          if (issue) begin
            cnt     <= cnt + 1'b1;
            cmp_idx <= issue_idx;
            if (!valid_bits[issue_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= issue_idx;
            end
          end
          if (match_now) begin
            hit      <= 1'b1;
            hit_idx  <= cmp_idx;
            hit_data <= ram_rdata.data;
          end
          // last compare is in flight when the counter has reached the end
          if (match_now || (cmp_valid && scan_end)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            if (item.op == kct_pkg::OP_SAVE && !hit && free_found) begin
              valid_bits[free_idx] <= 1'b1;
            end
            if (item.op == kct_pkg::OP_DELETE && hit) begin
              valid_bits[hit_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
